>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl
// expects clk and arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define MTG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication form, antecedent then consequent
`define MTG_ASSERT_IMP(label, ante, cons, msg) \
	`MTG_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> rtl/core/mtg_pkg.sv
// shared constants, types and state encoding for the mt19937 generator
// no dependencies
package mtg_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int SHIFT_OFFSET = 397;
	localparam int IDX_W        = 10;
	localparam int WORD_W       = 32;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

	localparam logic [WORD_W-1:0] TWIST_XOR_VECTOR = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] HIGH_BIT_MASK    = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOW_BITS_MASK    = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] INIT_MULTIPLIER  = 32'd1812433253;
	localparam logic [WORD_W-1:0] SEED_RESET       = 32'd5489;
	localparam logic [WORD_W-1:0] TEMPER_MASK_B    = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_MASK_C    = 32'hefc6_0000;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_RD_PAIR,
		ST_RD_FAR,
		ST_TWIST
	} mtg_state_t;

	typedef struct packed {
		logic fill_run;
		logic rd_pair;
		logic rd_far;
		logic twist;
	} mtg_cmd_t;

	typedef struct packed {
		logic fill_done;
		logic out_busy;
	} mtg_sts_t;

endpackage

>>> rtl/core/mtg_ctrl.sv
// controller state machine: table fill, reads and twist sequencing
// depends on mtg_pkg
module mtg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              reseed,
	output logic              in_stall,
	input  mtg_pkg::mtg_sts_t sts,
	output mtg_pkg::mtg_cmd_t cmd
);
	import mtg_pkg::*;

	mtg_state_t state_q, state_d;
	logic       pend_q;
	logic       accept;

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && reseed) begin
				pend_q <= 1'b1;
			end else if (state_q == ST_FILL && sts.fill_done) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (sts.fill_done) begin
					state_d = pend_q ? ST_RD_PAIR : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = reseed ? ST_FILL : ST_RD_PAIR;
				end
			end
			ST_RD_PAIR: state_d = ST_RD_FAR;
			ST_RD_FAR:  state_d = ST_TWIST;
			ST_TWIST: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		cmd.fill_run = 1'b0;
		cmd.rd_pair  = 1'b0;
		cmd.rd_far   = 1'b0;
		cmd.twist    = 1'b0;
		case (state_q)
			ST_FILL:    cmd.fill_run = 1'b1;
			ST_IDLE:    in_stall = 1'b0;
			ST_RD_PAIR: cmd.rd_pair = 1'b1;
			ST_RD_FAR:  cmd.rd_far = 1'b1;
			ST_TWIST:   cmd.twist = !sts.out_busy;
			default:    in_stall = 1'b1;
		endcase
	end

endmodule

>>> rtl/core/mtg_datapath.sv
// datapath: state table memory, fill recurrence, twist, tempering and output register
// depends on mtg_pkg
module mtg_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [mtg_pkg::WORD_W-1:0]  seed,
	input  mtg_pkg::mtg_cmd_t           cmd,
	output mtg_pkg::mtg_sts_t           sts,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mtg_pkg::WORD_W-1:0]  value
);
	import mtg_pkg::*;

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
		logic [WORD_W-1:0] y;
		y = y_in;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_MASK_B);
		y = y ^ ((y << 15) & TEMPER_MASK_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	logic [WORD_W-1:0] table_mem [STATE_WORDS];
	logic [WORD_W-1:0] rd_a_q, rd_b_q;
	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] prev_q;
	logic [IDX_W-1:0]  fill_k_q;
	logic [IDX_W-1:0]  idx_q;
	logic              hi_q;
	logic [WORD_W-1:0] value_q;
	logic              out_valid_q;

	logic [IDX_W-1:0]  nxt_idx, far_idx, rd_a_addr, wr_addr;
	logic [IDX_W:0]    far_sum;
	logic [WORD_W-1:0] prev_mix, fill_prod, fill_word;
	logic [WORD_W-1:0] mixed, twist_word, wr_data;
	logic              wr_en;

	assign nxt_idx = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign far_sum = {1'b0, idx_q} + (IDX_W + 1)'(SHIFT_OFFSET);
	assign far_idx = (far_sum >= (IDX_W + 1)'(STATE_WORDS))
		? IDX_W'(far_sum - (IDX_W + 1)'(STATE_WORDS)) : far_sum[IDX_W-1:0];
	assign rd_a_addr = cmd.rd_pair ? idx_q : far_idx;

	assign prev_mix  = prev_q ^ (prev_q >> 30);
	assign fill_prod = prev_mix * INIT_MULTIPLIER;
	assign fill_word = (fill_k_q == '0) ? seed_q
		: fill_prod + {{(WORD_W - IDX_W){1'b0}}, fill_k_q};

	assign mixed      = ({hi_q, {(WORD_W - 1){1'b0}}} & HIGH_BIT_MASK) | (rd_b_q & LOW_BITS_MASK);
	assign twist_word = rd_a_q ^ (mixed >> 1) ^ (rd_b_q[0] ? TWIST_XOR_VECTOR : '0);

	assign wr_en   = cmd.fill_run || cmd.twist;
	assign wr_addr = cmd.fill_run ? fill_k_q : idx_q;
	assign wr_data = cmd.fill_run ? fill_word : twist_word;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_data;
		end
		rd_a_q <= table_mem[rd_a_addr];
		rd_b_q <= table_mem[nxt_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= SEED_RESET;
			fill_k_q    <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				seed_q <= seed;
			end
			if (cmd.fill_run) begin
				fill_k_q <= (fill_k_q == LAST_IDX) ? '0 : fill_k_q + 1'b1;
				idx_q    <= '0;
			end else if (cmd.twist) begin
				idx_q <= nxt_idx;
			end
			if (cmd.twist) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_run) begin
			prev_q <= fill_word;
		end
		if (cmd.rd_far) begin
			hi_q <= rd_a_q[WORD_W-1];
		end
		if (cmd.twist) begin
			value_q <= temper(twist_word);
		end
	end

	assign sts.fill_done = cmd.fill_run && (fill_k_q == LAST_IDX);
	assign sts.out_busy  = out_valid_q && out_stall;
	assign out_valid     = out_valid_q;
	assign value         = value_q;

endmodule

>>> rtl/core/mersenne_twister_generator.sv
// MT19937 generator, one tempered 32-bit word per input transaction. After reset
// the 624-word state table is filled from the seed register (reset value 5489),
// one word a cycle, and no transaction is taken until the fill is done. For a
// transaction with reseed low the block reads the table, then twists: the current
// and following word are read together, the word 397 places on in the next cycle,
// and the twist writes the new word back and registers its tempered result. The
// block takes the next transaction only after the twist, once back in idle.
// The result sits in an output register, and a result still waiting there holds
// off the next twist. A transaction with reseed high first refills the table from
// the seed register, then proceeds as a transaction with reseed low.
// Writing the seed does not touch the table: it applies at the next reseed.
// depends on mtg_pkg, mtg_ctrl, mtg_datapath and assert_macros.svh
`include "assert_macros.svh"

module mersenne_twister_generator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mtg_pkg::WORD_W-1:0] seed,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       reseed,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [mtg_pkg::WORD_W-1:0] value
);
	import mtg_pkg::*;

	mtg_cmd_t cmd;
	mtg_sts_t sts;

	assign cfg_ready = 1'b1;

	mtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.reseed   (reseed),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mtg_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.seed      (seed),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value)
	);

	`MTG_ASSERT(a_one_at_a_time, (in_valid && !in_stall) |=> in_stall, "accept while busy")
	`MTG_ASSERT(a_twist_lands, cmd.twist |=> out_valid, "twist result lost")
	`MTG_ASSERT_IMP(a_result_from_twist, $rose(out_valid), $past(cmd.twist), "no twist")
	`MTG_ASSERT_IMP(a_no_twist_in_fill, cmd.fill_run, !cmd.twist && in_stall, "busy in fill")

endmodule
